/* sv/lhsv_pkg.sv */
// ============================================================================
// lhsv_pkg
// Shared types, constants and small tables of the HSV steady/breathing block.
// ============================================================================
package lhsv_pkg;

   // tick counter
   localparam int PHASE_STEPS = 40;
   localparam int PHASE_W     = 6;
   localparam int BREATH_STEP = 5;

   // register limits
   localparam int FULL_SAT = 1000;
   localparam int FULL_VAL = 100;

   // register indexes
   localparam logic [1:0] REG_HUE        = 2'd0;
   localparam logic [1:0] REG_SATURATION = 2'd1;
   localparam logic [1:0] REG_BRIGHTNESS = 2'd2;
   localparam logic [1:0] REG_MODE       = 2'd3;

   // effect mode codes
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_STEADY = 2'd1;
   localparam logic [1:0] MODE_BREATH = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // hue reduction: 8 steps of mod 360, then 3 steps of divide by 60
   localparam int HUE_MOD       = 360;
   localparam int SECTOR_SPAN   = 60;
   localparam int HUE_MOD_STEPS = 8;
   localparam int HUE_STEPS     = 11;

   // channel arithmetic, scaled down by 30:
   // level = floor((17 * v * X + 200000) / 400000), X = 60000 - m * s
   localparam int X_FULL     = 60000;
   localparam int ROUND_BIAS = 200000;
   localparam int DIVISOR    = 400000;
   localparam int M_W        = 6;      // width of m, serial steps of m * s
   localparam int W_W        = 11;     // width of 17 * v, serial steps of X * w
   localparam int Q_W        = 8;      // quotient bits per channel
   localparam int ACC_W      = 27;
   localparam int DIV_W      = 26;
   localparam int CHANNELS   = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HUE,
      ST_LOAD,
      ST_MULS,
      ST_MULV,
      ST_DIV,
      ST_DONE
   } state_type;

   // which HSV term feeds a channel
   typedef enum logic [1:0] {
      K_V,
      K_P,
      K_Q,
      K_T
   } kind_type;

   // restoring divisor of the hue reduction for a given step
   function automatic logic [15:0] hue_divisor(input logic [3:0] step);
      logic [15:0] r;
      if (step < 4'(HUE_MOD_STEPS)) begin
         r = 16'(HUE_MOD) << (4'(HUE_MOD_STEPS - 1) - step);
      end else begin
         r = 16'(SECTOR_SPAN) << (4'(HUE_STEPS - 1) - step);
      end
      return r;
   endfunction

   // sector / channel to term: (V,T,P) (Q,V,P) (P,V,T) (P,Q,V) (T,P,V) (V,P,Q)
   function automatic kind_type chan_kind(input logic [2:0] sector, input logic [1:0] chan);
      kind_type k0, k1, k2, k;
      case (sector)
         3'd0: begin k0 = K_V; k1 = K_T; k2 = K_P; end
         3'd1: begin k0 = K_Q; k1 = K_V; k2 = K_P; end
         3'd2: begin k0 = K_P; k1 = K_V; k2 = K_T; end
         3'd3: begin k0 = K_P; k1 = K_Q; k2 = K_V; end
         3'd4: begin k0 = K_T; k1 = K_P; k2 = K_V; end
         default: begin k0 = K_V; k1 = K_P; k2 = K_Q; end
      endcase
      case (chan)
         2'd0: k = k0;
         2'd1: k = k1;
         default: k = k2;
      endcase
      return k;
   endfunction

endpackage

/* sv/led_hsv_steady_breathing.sv */
// ============================================================================
// led_hsv_steady_breathing
// Per-tick LED color: HSV to RGB with a steady or breathing value, computed
// by a bit-serial multiply and restoring-divide datapath.
// ============================================================================
//
//  channel | ports                              | dir | carries
//  --------+------------------------------------+-----+-------------------------
//  req     | req_valid req_ready req_restart    | in  | one tick word
//  rsp     | rsp_valid rsp_ready rsp_red/green/blue | out | one color word
//  csr     | csr_valid csr_ready csr_index csr_wdata | in | register write
//
//  A tick in steady or breathing mode runs 11 hue reduction steps, then per
//  channel 1 load, 6 steps of m*s, 11 steps of X*(17*v) and 8 divide steps,
//  then hands off the color word once the output register is free and goes
//  back to idle, where the next tick is taken; all of it runs on one shared
//  serial multiplier/divider.
//  A tick in mode none gives no word. Reset sets brightness to 50.
//  Reset clears the tick counter, control and the other registers.
//  A color word waits in the output register while the next tick is taken; a
//  finished conversion holds until that register is free.
//
module led_hsv_steady_breathing
   import lhsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [15:0]        hue_ff;
   logic [9:0]         sat_ff;
   logic [6:0]         bri_ff;
   logic [1:0]         mode_ff;
   logic [PHASE_W-1:0] phase_ff, phase_in;

   logic [3:0]         step_ff;
   logic [1:0]         chan_ff;
   logic [15:0]        hrem_ff, hrem_in;
   logic [2:0]         sector_ff, sector_in;
   logic [6:0]         val_ff, val_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   mul_a_ff, mul_a_in;
   logic [W_W-1:0]     mul_b_ff, mul_b_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [23:0]        res_ff;
   logic               rsp_valid_ff;
   logic [23:0]        rsp_ff;

   logic               req_fire, rsp_fire, active_mode, slot_free, last_step;
   logic [15:0]        hdiv;
   logic               hue_ge, div_ge;
   logic [9:0]         sat_use;
   logic [W_W-1:0]     wmul;
   logic [M_W-1:0]     r60, m_sel;
   kind_type           kind;
   logic [PHASE_W:0]   ph_inc;
   logic [8:0]         lvl_up, lvl_dn, lvl;
   logic [ACC_W-1:0]   mul_term;

   // ---------------------------------------------------------------
   // Handshake and control outputs
   // ---------------------------------------------------------------
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      csr_ready   = 1'b1;
      req_fire    = req_valid && req_ready;
      rsp_fire    = rsp_valid_ff && rsp_ready;
      slot_free   = !rsp_valid_ff || rsp_ready;
      active_mode = (mode_ff == MODE_STEADY) || (mode_ff == MODE_BREATH);
      last_step   = 1'b0;
      unique case (state_ff)
         ST_HUE:  last_step = (step_ff == 4'(HUE_STEPS - 1));
         ST_MULS: last_step = (step_ff == 4'(M_W - 1));
         ST_MULV: last_step = (step_ff == 4'(W_W - 1));
         ST_DIV:  last_step = (step_ff == 4'(Q_W - 1));
         default: last_step = 1'b0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_ff[23:16];
   assign rsp_green = rsp_ff[15:8];
   assign rsp_blue  = rsp_ff[7:0];

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire && active_mode) state_in = ST_HUE;
         ST_HUE:  if (last_step) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_MULS;
         ST_MULS: if (last_step) state_in = ST_MULV;
         ST_MULV: if (last_step) state_in = ST_DIV;
         ST_DIV: begin
            if (last_step) state_in = (chan_ff == 2'(CHANNELS - 1)) ? ST_DONE : ST_LOAD;
         end
         ST_DONE: if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Tick phase and value for this tick
   // ---------------------------------------------------------------
   always_comb begin
      ph_inc   = (req_restart ? '0 : {1'b0, phase_ff}) + 1'b1;
      phase_in = (ph_inc == (PHASE_W+1)'(PHASE_STEPS)) ? '0 : ph_inc[PHASE_W-1:0];
      lvl_up   = 9'(phase_in) * 9'(BREATH_STEP);
      lvl_dn   = (9'(PHASE_STEPS) - 9'(phase_in)) * 9'(BREATH_STEP);
      lvl      = (9'(phase_in) < 9'(PHASE_STEPS / 2)) ? lvl_up : lvl_dn;
      if (mode_ff == MODE_BREATH) begin
         val_in = (lvl > 9'(FULL_VAL)) ? 7'(FULL_VAL) : lvl[6:0];
      end else begin
         val_in = (bri_ff > 7'(FULL_VAL)) ? 7'(FULL_VAL) : bri_ff;
      end
   end

   // ---------------------------------------------------------------
   // Hue reduction step and channel term selection
   // ---------------------------------------------------------------
   always_comb begin
      hdiv      = hue_divisor(step_ff);
      hue_ge    = (hrem_ff >= hdiv);
      hrem_in   = hue_ge ? (hrem_ff - hdiv) : hrem_ff;
      sector_in = (step_ff >= 4'(HUE_MOD_STEPS)) ? {sector_ff[1:0], hue_ge} : sector_ff;
      sat_use   = (sat_ff > 10'(FULL_SAT)) ? 10'(FULL_SAT) : sat_ff;
      // 17 * v
      wmul      = {val_ff, 4'b0000} + W_W'(val_ff);
      r60       = hrem_ff[M_W-1:0];
      kind      = chan_kind(sector_ff, chan_ff);
      case (kind)
         K_V:     m_sel = '0;
         K_P:     m_sel = M_W'(SECTOR_SPAN);
         K_Q:     m_sel = r60;
         default: m_sel = M_W'(SECTOR_SPAN) - r60;
      endcase
   end

   // ---------------------------------------------------------------
   // Serial datapath: one multiplier bit or one quotient bit per cycle
   // ---------------------------------------------------------------
   always_comb begin
      mul_term = mul_b_ff[0] ? mul_a_ff : '0;
      div_ge   = (acc_ff >= ACC_W'(div_ff));
      acc_in   = acc_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      div_in   = div_ff;
      case (state_ff)
         ST_LOAD: begin
            acc_in   = ACC_W'(X_FULL);
            mul_a_in = ACC_W'(sat_use);
            mul_b_in = W_W'(m_sel);
         end
         ST_MULS: begin
            // X = 60000 - m * s, never negative
            acc_in   = acc_ff - mul_term;
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            if (last_step) begin
               mul_a_in = acc_ff - mul_term;
               mul_b_in = wmul;
               acc_in   = ACC_W'(ROUND_BIAS);
            end
         end
         ST_MULV: begin
            acc_in   = acc_ff + mul_term;
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            if (last_step) div_in = DIV_W'(DIVISOR << (Q_W - 1));
         end
         ST_DIV: begin
            acc_in = div_ge ? (acc_ff - ACC_W'(div_ff)) : acc_ff;
            div_in = div_ff >> 1;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hue_ff       <= '0;
         sat_ff       <= '0;
         bri_ff       <= 7'(50);
         mode_ff      <= MODE_NONE;
         phase_ff     <= '0;
         step_ff      <= '0;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // register writes
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_HUE:        hue_ff  <= csr_wdata;
               REG_SATURATION: sat_ff  <= csr_wdata[9:0];
               REG_BRIGHTNESS: bri_ff  <= csr_wdata[6:0];
               REG_MODE:       mode_ff <= csr_wdata[1:0];
               default: ;
            endcase
         end

         // advance the tick counter on every accepted word
         if (req_fire) phase_ff <= phase_in;

         // step counter restarts whenever the state changes
         if (state_in != state_ff) begin
            step_ff <= '0;
         end else if (state_ff != ST_IDLE && state_ff != ST_DONE) begin
            step_ff <= step_ff + 1'b1;
         end

         if (req_fire) begin
            chan_ff <= '0;
         end else if (state_ff == ST_DIV && last_step) begin
            chan_ff <= chan_ff + 1'b1;
         end

         // output register: set on handoff, drop once taken
         if (state_ff == ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hrem_ff   <= hue_ff;
         sector_ff <= '0;
         val_ff    <= val_in;
      end else if (state_ff == ST_HUE) begin
         hrem_ff   <= hrem_in;
         sector_ff <= sector_in;
      end
      acc_ff   <= acc_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      div_ff   <= div_in;
      if (state_ff == ST_DIV) res_ff <= {res_ff[22:0], div_ge};
      if (state_ff == ST_DONE && slot_free) rsp_ff <= res_ff;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < PHASE_W'(PHASE_STEPS))
      else $error("tick phase out of range");

   a_none_no_work: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !active_mode) |=> (state_ff == ST_IDLE))
      else $error("mode none started a conversion");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("color word raised outside handoff");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD || state_ff == ST_MULS || state_ff == ST_MULV
       || state_ff == ST_DIV) |-> (chan_ff < 2'(CHANNELS)))
      else $error("channel index out of range");

endmodule

/* test/testbench.sv */
// ============================================================================
// testbench
// Sends tick words and register writes to led_hsv_steady_breathing. A local
// HSV to RGB predictor, with its own tick counter and register copies, gives
// the expected color words unless a directed row gives its own; words are checked in order.
// ============================================================================
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lhsv_pkg::*;

   localparam int unsigned RUN_LIMIT     = 1_000_000;
   localparam int          SETTLE_CYCLES = 120;    // a full conversion plus margin
   localparam int          RANDOM_TICKS  = 600;
   localparam int          IDLE_PCT      = 30;
   localparam longint unsigned CHAN_DENOM = 64'd6000000;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   // one directed tick, with an optional register update ahead of it
   typedef struct packed {
      logic [3:0]  wr_mask;
      logic [15:0] hue;
      logic [15:0] sat;
      logic [15:0] bright;
      logic [1:0]  mode;
      logic        restart;
      logic        typed;
      color_type   color;
   } tick_row_type;

   localparam logic [3:0] W_HUE    = 4'(1) << REG_HUE;
   localparam logic [3:0] W_SAT    = 4'(1) << REG_SATURATION;
   localparam logic [3:0] W_BRIGHT = 4'(1) << REG_BRIGHTNESS;
   localparam logic [3:0] W_MODE   = 4'(1) << REG_MODE;
   localparam logic [3:0] W_HSV    = W_HUE | W_SAT | W_BRIGHT;
   localparam logic [3:0] W_ALL    = W_HSV | W_MODE;

   localparam tick_row_type DIRECTED [21] = '{
      // register reset values: hue 0, saturation 0, brightness 50
      '{W_MODE, 16'd0, 16'd0, 16'd0, MODE_STEADY, 1'b0, 1'b1, '{8'd128, 8'd128, 8'd128}},
      // primaries at full saturation and value
      '{W_HSV, 16'd0, 16'd1000, 16'd100, MODE_STEADY, 1'b0, 1'b1, '{8'd255, 8'd0, 8'd0}},
      '{W_HUE, 16'd120, 16'd0, 16'd0, MODE_STEADY, 1'b0, 1'b1, '{8'd0, 8'd255, 8'd0}},
      '{W_HUE, 16'd240, 16'd0, 16'd0, MODE_STEADY, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd255}},
      // hue wraps modulo 360
      '{W_HUE, 16'd360, 16'd0, 16'd0, MODE_STEADY, 1'b0, 1'b1, '{8'd255, 8'd0, 8'd0}},
      '{W_HUE, 16'd65535, 16'd0, 16'd0, MODE_STEADY, 1'b0, 1'b1, '{8'd255, 8'd64, 8'd0}},
      // remaining sector starts, then hue 359 at half saturation
      '{W_HUE, 16'd60, 16'd0, 16'd0, MODE_STEADY, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{W_HUE, 16'd180, 16'd0, 16'd0, MODE_STEADY, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{W_HUE, 16'd300, 16'd0, 16'd0, MODE_STEADY, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{W_HSV, 16'd359, 16'd500, 16'd73, MODE_STEADY, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
      // saturation and brightness above full are clamped
      '{W_HSV, 16'd0, 16'd1023, 16'd127, MODE_STEADY, 1'b0, 1'b1, '{8'd255, 8'd0, 8'd0}},
      '{W_SAT | W_BRIGHT, 16'd0, 16'd0, 16'd100, MODE_STEADY, 1'b0, 1'b1,
        '{8'd255, 8'd255, 8'd255}},
      '{W_BRIGHT, 16'd0, 16'd0, 16'd0, MODE_STEADY, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0}},
      // breathing: restart puts the counter at phase 1, level 5
      '{W_ALL, 16'd0, 16'd0, 16'd100, MODE_BREATH, 1'b1, 1'b1, '{8'd13, 8'd13, 8'd13}},
      '{4'd0, 16'd0, 16'd0, 16'd0, MODE_BREATH, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{4'd0, 16'd0, 16'd0, 16'd0, MODE_BREATH, 1'b1, 1'b1, '{8'd13, 8'd13, 8'd13}},
      '{W_HUE | W_SAT, 16'd30, 16'd1000, 16'd0, MODE_BREATH, 1'b0, 1'b0,
        '{8'd0, 8'd0, 8'd0}},
      // mode none and the unused code give no word
      '{W_MODE, 16'd0, 16'd0, 16'd0, MODE_NONE, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{4'd0, 16'd0, 16'd0, 16'd0, MODE_NONE, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{W_MODE, 16'd0, 16'd0, 16'd0, MODE_UNUSED, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
      // back to steady mode after the silent ticks
      '{W_MODE, 16'd0, 16'd0, 16'd0, MODE_STEADY, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}}
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_restart = 1'b0;
   logic        rsp_ready   = 1'b0;
   logic        csr_valid   = 1'b0;
   logic [1:0]  csr_index   = REG_HUE;
   logic [15:0] csr_wdata   = 16'd0;
   logic        req_ready;
   logic        csr_ready;
   logic        rsp_valid;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;

   // typed expectation traveling with the tick word
   logic      row_typed = 1'b0;
   color_type row_color = '0;

   // predictor state
   color_type   color_q [$];
   logic [15:0] cfg_hue;
   logic [9:0]  cfg_sat;
   logic [6:0]  cfg_bright;
   logic [1:0]  cfg_mode;
   logic [5:0]  tick_cnt;

   int          err_cnt   = 0;
   int unsigned cycle_cnt = 0;
   int          stall_left = 0;
   logic        quiet     = 1'b0;
   string       chan_name [3] = '{"blue", "green", "red"};

   led_hsv_steady_breathing u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round num / CHAN_DENOM * 255 half up
   function automatic logic [7:0] round_level(input longint unsigned num);
      longint unsigned q;
      q = (510 * num + CHAN_DENOM) / (2 * CHAN_DENOM);
      return q[7:0];
   endfunction

   function automatic color_type hsv_color(input logic [15:0] hue_w, input logic [9:0] sat_w,
                                           input logic [6:0] val_w);
      longint unsigned h, s, v, r60, nv, np, nq, nt, a, b, c;
      longint unsigned sector;
      color_type       rgb;
      h      = hue_w % HUE_MOD;
      s      = (sat_w > FULL_SAT) ? FULL_SAT : sat_w;
      v      = (val_w > FULL_VAL) ? FULL_VAL : val_w;
      sector = h / SECTOR_SPAN;
      r60    = h % SECTOR_SPAN;
      nv     = v * X_FULL;
      np     = v * (FULL_SAT - s) * SECTOR_SPAN;
      nq     = v * (X_FULL - r60 * s);
      nt     = v * (X_FULL - (SECTOR_SPAN - r60) * s);
      case (sector)
         0: begin a = nv; b = nt; c = np; end
         1: begin a = nq; b = nv; c = np; end
         2: begin a = np; b = nv; c = nt; end
         3: begin a = np; b = nq; c = nv; end
         4: begin a = nt; b = np; c = nv; end
         default: begin a = nv; b = np; c = nq; end
      endcase
      rgb.red   = round_level(a);
      rgb.green = round_level(b);
      rgb.blue  = round_level(c);
      return rgb;
   endfunction

   // register value: often an extreme, sometimes junk above the register width
   function automatic logic [15:0] pick_reg(input int unsigned hi, input int unsigned lim,
                                            input int unsigned w);
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0: v = 16'd0;
         1: v = 16'(lim);
         2: v = 16'(lim + 1);
         3: v = 16'(hi);
         default: v = 16'($urandom_range(0, hi));
      endcase
      if (w < 16 && $urandom_range(0, 3) == 0) begin
         v = v | 16'($urandom() << w);
      end
      return v;
   endfunction

   // watch all three channels, keep the predictor, idle the color side
   always @(posedge clock) begin
      int unsigned level;
      color_type   want;
      color_type   got;
      got = {rsp_red, rsp_green, rsp_blue};
      if (reset) begin
         cfg_hue    = 16'd0;
         cfg_sat    = 10'd0;
         cfg_bright = 7'd50;
         cfg_mode   = MODE_NONE;
         tick_cnt   = '0;
      end else begin
         // check the color word against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (color_q.size() == 0) begin
               $display("%0t: color word with none expected: actual %0d %0d %0d",
                        $time, got.red, got.green, got.blue);
               err_cnt++;
            end else begin
               want = color_q.pop_front();
               for (int i = 0; i < 3; i++) begin
                  if (got[8*i +: 8] !== want[8*i +: 8]) begin
                     $display("%0t: %s mismatch: expected %0d, actual %0d", $time,
                              chan_name[i], want[8*i +: 8], got[8*i +: 8]);
                     err_cnt++;
                  end
               end
            end
         end
         // mirror register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_HUE:        cfg_hue    = csr_wdata;
               REG_SATURATION: cfg_sat    = csr_wdata[9:0];
               REG_BRIGHTNESS: cfg_bright = csr_wdata[6:0];
               REG_MODE:       cfg_mode   = csr_wdata[1:0];
               default: ;
            endcase
         end
         // advance the counter and predict the color of this tick
         if (req_valid && req_ready) begin
            if (req_restart) begin
               tick_cnt = '0;
            end
            tick_cnt = 6'((tick_cnt + 1) % PHASE_STEPS);
            if (cfg_mode == MODE_STEADY || cfg_mode == MODE_BREATH) begin
               if (cfg_mode == MODE_STEADY) begin
                  want = hsv_color(cfg_hue, cfg_sat, cfg_bright);
               end else begin
                  level = (tick_cnt < PHASE_STEPS / 2) ? tick_cnt * BREATH_STEP
                                                       : (PHASE_STEPS - tick_cnt) * BREATH_STEP;
                  if (level > FULL_VAL) begin
                     level = FULL_VAL;
                  end
                  want = hsv_color(cfg_hue, cfg_sat, 7'(level));
               end
               color_q.push_back(row_typed ? row_color : want);
            end
         end
      end
      // short random stalls, now and then a long one
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 199) == 0) begin
         stall_left = $urandom_range(20, 150);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == RUN_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // offer one tick word, maybe after a gap, and hold it until taken
   task automatic send_tick(input logic restart, input logic typed, input color_type color);
      if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 100)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      row_typed   <= typed;
      row_color   <= color;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   // hold off ticks until every expected color word has come
   task automatic drain_colors();
      req_valid <= 1'b0;
      do @(posedge clock); while (color_q.size() != 0);
   endtask

   // update registers only with the block idle
   task automatic apply_setting(input logic [3:0] mask, input logic [15:0] hue_w,
                                input logic [15:0] sat_w, input logic [15:0] bright_w,
                                input logic [15:0] mode_w);
      drain_colors();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if ((mask & W_HUE) != 0) write_reg(REG_HUE, hue_w);
      if ((mask & W_SAT) != 0) write_reg(REG_SATURATION, sat_w);
      if ((mask & W_BRIGHT) != 0) write_reg(REG_BRIGHTNESS, bright_w);
      if ((mask & W_MODE) != 0) write_reg(REG_MODE, mode_w);
      csr_valid <= 1'b0;
   endtask

   initial begin
      tick_row_type row;
      int unsigned  sent;
      int unsigned  run_len;
      logic [15:0]  mode_w;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         if (row.wr_mask != 0) begin
            apply_setting(row.wr_mask, row.hue, row.sat, row.bright, {14'd0, row.mode});
         end
         send_tick(row.restart, row.typed, row.color);
      end

      // random settings, each followed by a run of ticks
      sent = 0;
      while (sent < RANDOM_TICKS) begin
         quiet <= (sent >= 200 && sent < 300);
         case ($urandom_range(0, 9))
            0:       mode_w = {14'd0, MODE_NONE};
            1:       mode_w = {14'd0, MODE_UNUSED};
            2, 3, 4, 5: mode_w = {14'd0, MODE_STEADY};
            default: mode_w = {14'd0, MODE_BREATH};
         endcase
         if ($urandom_range(0, 3) == 0) begin
            mode_w[15:2] = 14'($urandom());
         end
         apply_setting(4'($urandom_range(1, 15)), pick_reg(65535, 359, 16),
                       pick_reg(1023, FULL_SAT, 10), pick_reg(127, FULL_VAL, 7), mode_w);
         run_len = $urandom_range(10, 60);
         repeat (run_len) begin
            if ($urandom_range(0, 49) == 0) begin
               drain_colors();
            end
            send_tick($urandom_range(0, 19) == 0, 1'b0, '0);
            sent++;
         end
      end

      // drop valid, collect what is left, let the block settle
      drain_colors();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_cnt == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
